@@ src/icc_pkg.sv @@
// Shared types, codes and constants of the isoline cell crossing block.
package icc_pkg;

  localparam int NUM_REGIONS_DEF = 5;
  localparam int GRID_DIM = 1024;
  localparam int MAX_OUT = 16;
  localparam int FRAC_BITS = 16;
  localparam int COORD_W = 26;
  localparam int SAMPLE_W = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX = 2'd1;

  localparam logic [1:0] EDGE_BOTTOM = 2'd0;
  localparam logic [1:0] EDGE_LEFT   = 2'd1;
  localparam logic [1:0] EDGE_RIGHT  = 2'd2;
  localparam logic [1:0] EDGE_TOP    = 2'd3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic                 en;
    logic [CFG_IDX_W-1:0] idx;
    logic [SAMPLE_W-1:0]  data;
  } cfg_wr_t;

  typedef struct packed {
    coord_t     x_base;
    coord_t     y_base;
    logic       on_x;
    logic [1:0] level;
    logic [1:0] edge_idx;
    logic       last;
  } crs_t;

endpackage

@@ src/icc_if.sv @@
// Channel interfaces: grid cells in, crossing points out, register writes.
interface icc_cell_if;
  import icc_pkg::*;
  logic    valid;
  logic    ready;
  sample_t value_low_left;
  sample_t value_low_right;
  sample_t value_up_left;
  sample_t value_up_right;
  logic [9:0] cell_column;
  logic [9:0] cell_row;
  modport source (output valid, value_low_left, value_low_right, value_up_left,
                  value_up_right, cell_column, cell_row, input ready);
  modport sink (input valid, value_low_left, value_low_right, value_up_left,
                value_up_right, cell_column, cell_row, output ready);
endinterface

interface icc_point_if;
  import icc_pkg::*;
  logic       valid;
  logic       ready;
  coord_t     point_x;
  coord_t     point_y;
  logic [1:0] level_index;
  logic [1:0] edge_index;
  logic       last_point;
  modport source (output valid, point_x, point_y, level_index, edge_index, last_point,
                  input ready);
  modport sink (input valid, point_x, point_y, level_index, edge_index, last_point,
                output ready);
endinterface

interface icc_cfg_if;
  import icc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SAMPLE_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ src/icc_levels.sv @@
// Range registers and the sequencer that derives the contour levels from them.
module icc_levels #(
  parameter int NUM_REGIONS = icc_pkg::NUM_REGIONS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  icc_pkg::cfg_wr_t                           wr,
  output logic [NUM_REGIONS-2:0][icc_pkg::SAMPLE_W-1:0] levels,
  output logic                                       busy
);
  import icc_pkg::*;

  localparam int RW = $clog2(NUM_REGIONS);
  localparam int KW = $clog2(NUM_REGIONS);
  localparam logic [RW:0] NR = (RW+1)'(NUM_REGIONS);
  // Scaled reciprocal of NUM_REGIONS; exact for every 33-bit span after a shift by SH.
  localparam int SH = 33 + RW;
  localparam logic [63:0] RECIP =
    ((64'd1 << SH) + 64'(NUM_REGIONS) - 64'd1) / 64'(NUM_REGIONS);
  localparam logic [17:0] RECIP_LO = RECIP[17:0];
  localparam logic [16:0] RECIP_HI = RECIP[34:18];
  localparam logic [32:0] NR_Q = 33'(NUM_REGIONS);

  typedef enum logic [5:0] {
    LV_IDLE = 6'b000001,
    LV_LOAD = 6'b000010,
    LV_MUL  = 6'b000100,
    LV_QUO  = 6'b001000,
    LV_REM  = 6'b010000,
    LV_ACC  = 6'b100000
  } lv_state_t;

  lv_state_t     state;
  logic [31:0]   rmin, rmax;
  logic [32:0]   num, dvd, acc_q;
  logic [50:0]   plo;
  logic [49:0]   phi;
  logic [RW-1:0] rem, acc_r;
  logic          neg;
  logic [KW-1:0] k;

  logic [32:0] diff, nq, qn;
  logic [69:0] prod;
  logic [RW:0] sr, nr;
  logic        c;
  logic [33:0] lv;

  assign diff = {rmax[31], rmax} - {rmin[31], rmin};
  assign prod = 70'(plo) + 70'({phi, 18'd0});
  assign qn   = dvd * NR_Q;
  assign sr   = {1'b0, acc_r} + {1'b0, rem};
  assign c    = sr >= NR;
  assign nr   = c ? sr - NR : sr;
  assign nq   = acc_q + dvd + 33'(c);
  assign lv   = {{2{rmin[31]}}, rmin} + (neg ? -{1'b0, nq} : {1'b0, nq});
  assign busy = state != LV_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= LV_IDLE;
      rmin   <= '0;
      rmax   <= '0;
      levels <= '0;
    end else begin
      unique case (state)
        LV_IDLE: ;
        LV_LOAD: begin
          num   <= diff[32] ? -diff : diff;
          neg   <= diff[32];
          state <= LV_MUL;
        end
        LV_MUL: begin
          // The reciprocal is split in two halves to keep each product narrow.
          plo   <= 51'(num) * 51'(RECIP_LO);
          phi   <= 50'(num) * 50'(RECIP_HI);
          state <= LV_QUO;
        end
        LV_QUO: begin
          dvd   <= prod[SH +: 33];
          state <= LV_REM;
        end
        LV_REM: begin
          rem   <= RW'(num - qn);
          acc_q <= '0;
          acc_r <= '0;
          k     <= '0;
          state <= LV_ACC;
        end
        LV_ACC: begin
          for (int j = 0; j < NUM_REGIONS - 1; j++) begin
            if (k == KW'(j)) levels[j] <= lv[31:0];
          end
          acc_q <= nq;
          acc_r <= RW'(nr);
          k     <= k + KW'(1);
          if (k == KW'(NUM_REGIONS - 2)) state <= LV_IDLE;
        end
        default: state <= LV_IDLE;
      endcase
      if (wr.en && wr.idx == REG_RANGE_MIN) begin
        rmin  <= wr.data;
        state <= LV_LOAD;
      end else if (wr.en && wr.idx == REG_RANGE_MAX) begin
        rmax  <= wr.data;
        state <= LV_LOAD;
      end
    end
  end
endmodule

@@ src/icc_div.sv @@
// Pipelined fraction divider, one quotient bit per stage, payload alongside.
module icc_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             in_vld,
  input  icc_pkg::sample_t in_a,
  input  icc_pkg::sample_t in_b,
  input  icc_pkg::sample_t in_lvl,
  input  icc_pkg::crs_t    in_info,
  output logic             out_vld,
  output logic [icc_pkg::FRAC_BITS:0] out_frac,
  output icc_pkg::crs_t    out_info
);
  import icc_pkg::*;

  localparam int QB = FRAC_BITS + 1;

  logic          raw_vld;
  sample_t       raw_a, raw_b, raw_l;
  crs_t          raw_info;
  logic          vld  [QB+1];
  logic [32:0]   rem  [QB+1];
  logic [31:0]   den  [QB+1];
  logic [QB-1:0] quo  [QB+1];
  crs_t          info [QB+1];

  logic [32:0] dn, dd;

  function automatic logic [33:0] div_step(logic [32:0] r, logic [31:0] d, logic first);
    logic [32:0] rr;
    logic        g;
    rr = first ? r : {r[31:0], 1'b0};
    g  = rr >= {1'b0, d};
    return {g, g ? rr - {1'b0, d} : rr};
  endfunction

  assign dn = {in_lvl[31], in_lvl} - {in_a[31], in_a};
  assign dd = {raw_b[31], raw_b} - {raw_a[31], raw_a};

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_vld <= 1'b0;
      for (int j = 0; j <= QB; j++) vld[j] <= 1'b0;
    end else if (adv) begin
      raw_vld <= in_vld;
      vld[0]  <= raw_vld;
      for (int j = 1; j <= QB; j++) vld[j] <= vld[j-1];
    end
  end

  always_ff @(posedge clk) begin
    logic [33:0] s;
    logic [32:0] an;
    if (adv) begin
      raw_a    <= in_a;
      raw_b    <= in_b;
      raw_info <= in_info;
      an       = dn[32] ? -dn : dn;
      raw_l    <= sample_t'(an[31:0]);
      rem[0]   <= {1'b0, raw_l};
      den[0]   <= dd[32] ? 32'(-dd) : dd[31:0];
      quo[0]   <= '0;
      info[0]  <= raw_info;
      for (int j = 1; j <= QB; j++) begin
        s       = div_step(rem[j-1], den[j-1], j == 1);
        rem[j]  <= s[32:0];
        den[j]  <= den[j-1];
        quo[j]  <= {quo[j-1][QB-2:0], s[33]};
        info[j] <= info[j-1];
      end
    end
  end

  assign out_vld  = vld[QB];
  assign out_frac = (den[QB] == '0) ? '0 : quo[QB];
  assign out_info = info[QB];
endmodule

@@ src/isoline_cell_crossings.sv @@
// Top level: marching squares crossing points for one grid cell per word.
//
//  channel  dir  modport        word
//  cells    in   icc_cell_if    four Q16.16 corner samples, column, row
//  points   out  icc_point_if   one crossing: x, y, level, edge, last flag
//  cfg      in   icc_cfg_if     register index and 32-bit write data
//
// A cell word waits in the front stage until the serializer takes it; the
// serializer then emits one crossing per cycle while points is not stalled.
// Each crossing goes through the divider's registers into the point register.
// A range write keeps the level sequencer busy through load, multiply, quotient,
// remainder and accumulate; cells.ready is low meanwhile. cfg.ready is always high.
// rst is synchronous. A stall on points freezes the divider pipe and serializer.
module isoline_cell_crossings #(
  parameter int NUM_REGIONS = icc_pkg::NUM_REGIONS_DEF
) (
  input logic         clk,
  input logic         rst,
  icc_cell_if.sink    cells,
  icc_point_if.source points,
  icc_cfg_if.sink     cfg
);
  import icc_pkg::*;

  localparam int M  = 4 * (NUM_REGIONS - 1);
  localparam int CW = $clog2(MAX_OUT);

  // Level registers, rebuilt by a short sequencer after every range write.
  logic [NUM_REGIONS-2:0][SAMPLE_W-1:0] levels;
  logic    busy;
  cfg_wr_t wr;

  assign cfg.ready = 1'b1;
  assign wr.en   = cfg.valid;
  assign wr.idx  = cfg.index;
  assign wr.data = cfg.data;

  icc_levels #(.NUM_REGIONS(NUM_REGIONS)) u_levels (
    .clk(clk), .rst(rst), .wr(wr), .levels(levels), .busy(busy)
  );

  // Front stage: the accepted cell word.
  logic       s1_vld;
  sample_t    s1_v [4];
  logic [9:0] s1_col, s1_row;

  // Serializer stage: corners, corner bases and the mask of crossings left.
  logic          s2_vld;
  sample_t       s2_v [4];
  coord_t        s2_x0, s2_y0;
  logic [M-1:0]  s2_mask;
  logic [CW-1:0] s2_cnt;

  logic adv, s1_take, s2_take, s2_done, emit;
  logic [M-1:0] mask_c, sel_oh, mask_after;
  sample_t      sel_lvl, sel_a, sel_b;
  crs_t         sel_info;
  logic         out_grid;

  logic          dv_vld;
  logic [FRAC_BITS:0] dv_frac;
  crs_t          dv_info;

  // Bracket test per level and edge; levels with an odd edge count and off-grid cells drop out.
  always_comb begin
    logic le [4];
    logic ge [4];
    logic [3:0] br;
    mask_c = '0;
    for (int k = 0; k < NUM_REGIONS - 1; k++) begin
      for (int c = 0; c < 4; c++) begin
        le[c] = s1_v[c] <= $signed(levels[k]);
        ge[c] = s1_v[c] >= $signed(levels[k]);
      end
      br[0] = (le[0] & ge[1]) | (le[1] & ge[0]);
      br[1] = (le[0] & ge[2]) | (le[2] & ge[0]);
      br[2] = (le[1] & ge[3]) | (le[3] & ge[1]);
      br[3] = (le[2] & ge[3]) | (le[3] & ge[2]);
      if (^br) br = '0;
      mask_c[4*k +: 4] = br;
    end
    out_grid = (32'(s1_col) > 32'(GRID_DIM - 2)) || (32'(s1_row) > 32'(GRID_DIM - 2));
    if (out_grid) mask_c = '0;
  end

  // Pick the lowest pending crossing: level order first, then edge order.
  always_comb begin
    sel_oh         = '0;
    sel_lvl        = '0;
    sel_info.level = '0;
    sel_info.edge_idx = EDGE_BOTTOM;
    for (int i = M - 1; i >= 0; i--) begin
      if (s2_mask[i]) begin
        sel_oh            = '0;
        sel_oh[i]         = 1'b1;
        sel_lvl           = $signed(levels[i/4]);
        sel_info.level    = 2'(i / 4);
        sel_info.edge_idx = 2'(i % 4);
      end
    end
    mask_after = s2_mask & ~sel_oh;
    sel_info.last = (mask_after == '0) || (s2_cnt == CW'(MAX_OUT - 1));
    unique case (sel_info.edge_idx)
      EDGE_BOTTOM: begin
        sel_a = s2_v[0]; sel_b = s2_v[1];
        sel_info.x_base = s2_x0; sel_info.y_base = s2_y0; sel_info.on_x = 1'b1;
      end
      EDGE_LEFT: begin
        sel_a = s2_v[0]; sel_b = s2_v[2];
        sel_info.x_base = s2_x0; sel_info.y_base = s2_y0; sel_info.on_x = 1'b0;
      end
      EDGE_RIGHT: begin
        sel_a = s2_v[1]; sel_b = s2_v[3];
        sel_info.x_base = s2_x0 + COORD_W'(1 << FRAC_BITS);
        sel_info.y_base = s2_y0; sel_info.on_x = 1'b0;
      end
      EDGE_TOP: begin
        sel_a = s2_v[2]; sel_b = s2_v[3];
        sel_info.x_base = s2_x0;
        sel_info.y_base = s2_y0 + COORD_W'(1 << FRAC_BITS); sel_info.on_x = 1'b1;
      end
      default: begin
        sel_a = s2_v[0]; sel_b = s2_v[1];
        sel_info.x_base = s2_x0; sel_info.y_base = s2_y0; sel_info.on_x = 1'b1;
      end
    endcase
  end

  // The divider pipe and serializer move only when the point register frees up.
  assign adv     = !points.valid || points.ready;
  assign emit    = s2_vld && (s2_mask != '0) && adv;
  assign s2_done = s2_vld && ((s2_mask == '0) || (emit && sel_info.last));
  assign s2_take = !s2_vld || s2_done;
  assign s1_take = !s1_vld || s2_take;
  assign cells.ready = s1_take && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      if (s1_take) s1_vld <= cells.valid && cells.ready;
      if (s2_take) s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_v[0] <= cells.value_low_left;
      s1_v[1] <= cells.value_low_right;
      s1_v[2] <= cells.value_up_left;
      s1_v[3] <= cells.value_up_right;
      s1_col  <= cells.cell_column;
      s1_row  <= cells.cell_row;
    end
    if (s2_take) begin
      s2_v    <= s1_v;
      // Corners sit half a cell in: index plus 0.5 in Q10.16.
      s2_x0   <= {s1_col, 1'b1, 15'd0};
      s2_y0   <= {s1_row, 1'b1, 15'd0};
      s2_mask <= mask_c;
      s2_cnt  <= '0;
    end else if (emit) begin
      s2_mask <= mask_after;
      s2_cnt  <= s2_cnt + CW'(1);
    end
  end

  icc_div u_div (
    .clk(clk), .rst(rst), .adv(adv), .in_vld(emit),
    .in_a(sel_a), .in_b(sel_b), .in_lvl(sel_lvl), .in_info(sel_info),
    .out_vld(dv_vld), .out_frac(dv_frac), .out_info(dv_info)
  );

  // Point register: add the fraction along the edge's axis, wrapping at 26 bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      points.valid <= 1'b0;
    end else if (adv) begin
      points.valid <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      points.point_x     <= dv_info.x_base + (dv_info.on_x ? COORD_W'(dv_frac) : '0);
      points.point_y     <= dv_info.y_base + (dv_info.on_x ? '0 : COORD_W'(dv_frac));
      points.level_index <= dv_info.level;
      points.edge_index  <= dv_info.edge_idx;
      points.last_point  <= dv_info.last;
    end
  end

`ifndef NO_ASSERTIONS
  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    cfg.valid && (cfg.index == REG_RANGE_MIN || cfg.index == REG_RANGE_MAX) |=> busy)
    else $error("range write did not start the level sequencer");
  a_busy_block: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cells.ready)
    else $error("cell taken while levels are rebuilt");
  a_cap: assert property (@(posedge clk) disable iff (rst)
    emit && s2_cnt == CW'(MAX_OUT - 1) |-> sel_info.last)
    else $error("cell emitted more than the crossing cap");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    s2_vld && !adv && s2_mask != '0 |=> s2_vld && $stable(s2_mask))
    else $error("serializer moved during an output stall");
`endif
endmodule

@@ sim/tb_isoline_cell_crossings.sv @@
// Self-checking testbench for the isoline cell crossing block.
`timescale 1ns / 1ps

module tb_isoline_cell_crossings;
  import icc_pkg::*;

  localparam int LEVELS = NUM_REGIONS_DEF - 1;
  localparam int DRAIN_CYCLES = 60;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam longint Q16_ONE = 65536;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam longint S32_MAX = 2147483647;

  // Idling patterns: sender idles 27 / receiver 77, then swapped, then none.
  typedef enum int {IDLE_SLOW_SINK, IDLE_SLOW_SOURCE, IDLE_NONE} idle_mode_t;

  typedef struct {
    sample_t    ll;
    sample_t    lr;
    sample_t    ul;
    sample_t    ur;
    logic [9:0] col;
    logic [9:0] row;
  } cell_t;

  typedef struct {
    coord_t     x;
    coord_t     y;
    logic [1:0] lvl;
    logic [1:0] edg;
    logic       last;
  } point_t;

  // Holds the configured range and the crossing points still owed by the block.
  class crossing_book;
    longint lo_reg;
    longint hi_reg;
    point_t owed[$];
    int     errors;

    function new();
      lo_reg = 0;
      hi_reg = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] val);
      if (idx == REG_RANGE_MIN) lo_reg = longint'(signed'(val));
      else if (idx == REG_RANGE_MAX) hi_reg = longint'(signed'(val));
    endfunction

    function longint level_value(int lv);
      return lo_reg + ((longint'(lv + 1) * (hi_reg - lo_reg)) / NUM_REGIONS_DEF);
    endfunction

    function bit spans(longint a, longint b, longint lvl);
      return (a <= lvl && lvl <= b) || (b <= lvl && lvl <= a);
    endfunction

    function longint unsigned edge_frac(longint a, longint b, longint lvl);
      longint num;
      longint den;
      num = lvl - a;
      den = b - a;
      if (num < 0) num = -num;
      if (den < 0) den = -den;
      if (den == 0) return 0;
      return (longint'(num) << 16) / den;
    endfunction

    // Works out every crossing of an accepted cell.
    function void add_cell(cell_t c);
      longint v0, v1, v2, v3, lvl;
      longint unsigned x0, y0;
      point_t hits[$];
      point_t p;
      int count;
      v0 = longint'(c.ll);
      v1 = longint'(c.lr);
      v2 = longint'(c.ul);
      v3 = longint'(c.ur);
      x0 = (longint'(c.col) << 16) + 32768;
      y0 = (longint'(c.row) << 16) + 32768;
      count = 0;
      if (c.col > GRID_DIM - 2 || c.row > GRID_DIM - 2) return;
      for (int lv = 0; lv < LEVELS; lv++) begin
        lvl = level_value(lv);
        hits.delete();
        p.lvl = lv[1:0];
        p.last = 1'b0;
        if (spans(v0, v1, lvl)) begin
          p.x = coord_t'(x0 + edge_frac(v0, v1, lvl)); p.y = coord_t'(y0);
          p.edg = EDGE_BOTTOM; hits = {hits, p};
        end
        if (spans(v0, v2, lvl)) begin
          p.x = coord_t'(x0); p.y = coord_t'(y0 + edge_frac(v0, v2, lvl));
          p.edg = EDGE_LEFT; hits = {hits, p};
        end
        if (spans(v1, v3, lvl)) begin
          p.x = coord_t'(x0 + Q16_ONE); p.y = coord_t'(y0 + edge_frac(v1, v3, lvl));
          p.edg = EDGE_RIGHT; hits = {hits, p};
        end
        if (spans(v2, v3, lvl)) begin
          p.x = coord_t'(x0 + edge_frac(v2, v3, lvl)); p.y = coord_t'(y0 + Q16_ONE);
          p.edg = EDGE_TOP; hits = {hits, p};
        end
        // A level that crosses an odd number of edges is dropped whole.
        if (hits.size() % 2 == 0) begin
          foreach (hits[k]) begin
            if (count < MAX_OUT) begin
              owed = {owed, hits[k]};
              count++;
            end
          end
        end
      end
      if (count > 0) owed[owed.size() - 1].last = 1'b1;
    endfunction

    function void check_point(point_t got);
      point_t want;
      if (owed.size() == 0) begin
        $error("unexpected point x=%0h y=%0h", got.x, got.y);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.x !== want.x) begin
        $error("point_x expected %0h actual %0h", want.x, got.x); errors++;
      end
      if (got.y !== want.y) begin
        $error("point_y expected %0h actual %0h", want.y, got.y); errors++;
      end
      if (got.lvl !== want.lvl) begin
        $error("level_index expected %0d actual %0d", want.lvl, got.lvl); errors++;
      end
      if (got.edg !== want.edg) begin
        $error("edge_index expected %0d actual %0d", want.edg, got.edg); errors++;
      end
      if (got.last !== want.last) begin
        $error("last_point expected %0b actual %0b", want.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  icc_cell_if  cells ();
  icc_point_if points ();
  icc_cfg_if   cfg ();

  isoline_cell_crossings dut (
    .clk    (clk),
    .rst    (rst),
    .cells  (cells.sink),
    .points (points.source),
    .cfg    (cfg.sink)
  );

  crossing_book book = new();
  idle_mode_t   mode = IDLE_NONE;
  bit           hold_armed = 1'b0;
  bit           hold_done = 1'b0;
  int           hold_left = 0;
  int           stall_count = 0;

  // 20 ns clock.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Receiver side: check every accepted point word, then choose the next ready.
  // A long hold-off, once armed, keeps ready low while the sender keeps
  // offering cells, so the block backs up and drops cells.ready.
  always @(posedge clk) begin
    if (!rst && points.valid && points.ready) begin
      book.check_point('{points.point_x, points.point_y, points.level_index,
                         points.edge_index, points.last_point});
    end
    if (hold_armed && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      points.ready <= 1'b0;
    end else if (mode == IDLE_SLOW_SINK) begin
      points.ready <= ($urandom_range(0, 99) >= 77);
    end else if (mode == IDLE_SLOW_SOURCE) begin
      points.ready <= ($urandom_range(0, 99) >= 27);
    end else begin
      points.ready <= 1'b1;
    end
  end

  // Watchdog: too long without any word moving on any channel ends the run.
  always @(posedge clk) begin
    if (rst || (cells.valid && cells.ready) || (points.valid && points.ready) ||
        (cfg.valid && cfg.ready)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("FAIL isoline_cell_crossings");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  function bit sender_idles();
    if (mode == IDLE_SLOW_SINK) return $urandom_range(0, 99) < 27;
    if (mode == IDLE_SLOW_SOURCE) return $urandom_range(0, 99) < 77;
    return 1'b0;
  endfunction

  // Offers one cell word and waits for it to be taken. Valid stays high
  // afterwards; the next send_cell or drain_cells sets it anew.
  task automatic send_cell(cell_t c);
    while (sender_idles()) begin
      cells.valid <= 1'b0;
      @(posedge clk);
    end
    cells.valid           <= 1'b1;
    cells.value_low_left  <= c.ll;
    cells.value_low_right <= c.lr;
    cells.value_up_left   <= c.ul;
    cells.value_up_right  <= c.ur;
    cells.cell_column     <= c.col;
    cells.cell_row        <= c.row;
    @(posedge clk);
    while (!cells.ready) @(posedge clk);
    book.add_cell(c);
  endtask

  // Stops offering cells and lets every owed point come out, plus a margin
  // for cells that produce nothing but may still be in the pipe.
  task automatic drain_cells();
    cells.valid <= 1'b0;
    @(posedge clk);
    while (book.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val[31:0];
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    book.write_reg(idx, val[31:0]);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_range(longint lo, longint hi);
    write_reg(REG_RANGE_MIN, lo);
    write_reg(REG_RANGE_MAX, hi);
  endtask

  function automatic cell_t make_cell(longint a, longint b, longint c, longint d,
                                      int col, int row);
    cell_t t;
    t.ll = a[31:0];
    t.lr = b[31:0];
    t.ul = c[31:0];
    t.ur = d[31:0];
    t.col = col[9:0];
    t.row = row[9:0];
    return t;
  endfunction

  // Corner sample for random cells: mostly inside the configured range so that
  // levels get crossed, sometimes exactly on a level, sometimes anything.
  function automatic longint pick_sample();
    longint lo, hi;
    longint unsigned span;
    int pick;
    lo = (book.lo_reg < book.hi_reg) ? book.lo_reg : book.hi_reg;
    hi = (book.lo_reg < book.hi_reg) ? book.hi_reg : book.lo_reg;
    pick = $urandom_range(0, 99);
    if (pick < 15) return longint'($signed($urandom));
    if (pick < 30) return book.level_value($urandom_range(0, LEVELS - 1));
    span = hi - lo + 1;
    return lo + longint'({$urandom, $urandom} % span);
  endfunction

  function automatic cell_t random_cell();
    longint s;
    int col, row;
    col = ($urandom_range(0, 99) < 92) ? $urandom_range(0, GRID_DIM - 2) : GRID_DIM - 1;
    row = ($urandom_range(0, 99) < 92) ? $urandom_range(0, GRID_DIM - 2) : GRID_DIM - 1;
    if ($urandom_range(0, 99) < 10) begin
      s = pick_sample();
      return make_cell(s, s, s, s, col, row);
    end
    return make_cell(pick_sample(), pick_sample(), pick_sample(), pick_sample(), col, row);
  endfunction

  // One random phase: the three idling patterns in turn, optionally with the
  // long receiver hold-off early in the fully busy stretch.
  task automatic random_phase(int n, bit with_hold);
    for (int i = 0; i < n; i++) begin
      if (i < n / 3) mode = IDLE_SLOW_SINK;
      else if (i < 2 * n / 3) mode = IDLE_SLOW_SOURCE;
      else mode = IDLE_NONE;
      if (with_hold && i == 2 * n / 3 + 2) hold_armed = 1'b1;
      send_cell(random_cell());
    end
    drain_cells();
  endtask

  initial begin
    rst                   <= 1'b1;
    cells.valid           <= 1'b0;
    cells.value_low_left  <= '0;
    cells.value_low_right <= '0;
    cells.value_up_left   <= '0;
    cells.value_up_right  <= '0;
    cells.cell_column     <= '0;
    cells.cell_row        <= '0;
    cfg.valid             <= 1'b0;
    cfg.index             <= REG_RANGE_MIN;
    cfg.data              <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Range left at reset: every level sits at zero.
    random_phase(9, 1'b0);

    // Directed cells with levels at 1.0, 2.0, 3.0 and 4.0.
    set_range(0, 5 * Q16_ONE);
    mode = IDLE_NONE;
    // Flat cell below every level, then flat exactly on a level: equal ends
    // give fraction zero on every edge.
    send_cell(make_cell(0, 0, 0, 0, 3, 4));
    send_cell(make_cell(Q16_ONE, Q16_ONE, Q16_ONE, Q16_ONE, 3, 4));
    // Single raised corner: two crossings per level.
    send_cell(make_cell(0, 0, 0, 5 * Q16_ONE, 10, 20));
    send_cell(make_cell(5 * Q16_ONE, 0, 0, 0, 0, 0));
    // Saddle: every edge crosses every level, the full sixteen points.
    send_cell(make_cell(0, 5 * Q16_ONE, 5 * Q16_ONE, 0, 7, 7));
    send_cell(make_cell(5 * Q16_ONE, 0, 0, 5 * Q16_ONE, 0, 1022));
    // Odd count: the bottom edge sits on the level, and it and both side edges cross it.
    send_cell(make_cell(Q16_ONE, Q16_ONE, 0, 0, 5, 5));
    // Corners at the extremes of the sample range.
    send_cell(make_cell(S32_MIN, S32_MAX, S32_MIN, S32_MAX, 1022, 0));
    send_cell(make_cell(S32_MAX, S32_MAX, S32_MIN, S32_MIN, 1022, 1022));
    send_cell(make_cell(S32_MIN, S32_MIN, S32_MIN, S32_MIN, 0, 0));
    send_cell(make_cell(S32_MAX, S32_MIN, S32_MAX, S32_MIN, 512, 341));
    // Cells off the grid's last column or row produce nothing.
    send_cell(make_cell(0, 5 * Q16_ONE, 5 * Q16_ONE, 0, 1023, 5));
    send_cell(make_cell(0, 5 * Q16_ONE, 5 * Q16_ONE, 0, 5, 1023));
    send_cell(make_cell(0, 5 * Q16_ONE, 5 * Q16_ONE, 0, 1023, 1023));
    // Fractional crossings along each edge direction.
    send_cell(make_cell(32768, 4 * Q16_ONE + 7, 3 * Q16_ONE, 123457, 100, 200));
    send_cell(make_cell(4 * Q16_ONE + 99, 12345, 65535, 5 * Q16_ONE - 1, 681, 682));
    drain_cells();
    random_phase(45, 1'b1);

    set_range(-Q16_ONE, Q16_ONE);
    random_phase(45, 1'b0);

    // Full signed range, then reversed: the level arithmetic needs 33 bits.
    set_range(S32_MIN, S32_MAX);
    send_cell(make_cell(S32_MIN, S32_MAX, S32_MAX, S32_MIN, 1, 2));
    drain_cells();
    random_phase(40, 1'b0);

    set_range(S32_MAX, S32_MIN);
    random_phase(40, 1'b0);

    // Empty range: every level lands on the same value.
    set_range(100, 100);
    random_phase(30, 1'b0);

    if (book.errors == 0) begin
      $display("PASS isoline_cell_crossings");
    end else begin
      $display("FAIL isoline_cell_crossings");
    end
    $finish;
  end

endmodule
